FILE: hdl/csvfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSV field splitter package
// Shared types, character codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    // Parameter defaults
    localparam int SEP_MAX_DEFAULT     = 4;
    localparam int FIELD_LIMIT_DEFAULT = 1024;

    // Fixed field widths
    localparam int CHAR_W  = 8;
    localparam int SEPL_W  = 3;
    localparam int SEPC_W  = 32;
    localparam int IDX_W   = 10;
    localparam int POS_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = SEPC_W;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_CHARS  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [SEPL_W-1:0] SEP_LENGTH_RESET = 3'd1;
    localparam logic [SEPC_W-1:0] SEP_CHARS_RESET  = 32'h0000_002C;

    // Parse modes
    typedef enum logic [1:0] {
        MODE_UNQUOTED = 2'd0,
        MODE_QUOTED   = 2'd1,
        MODE_QQUOTE   = 2'd2,
        MODE_SEP      = 2'd3
    } parse_mode_t;

    // One result of the parser
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              field_end;
        logic              row_end;
        logic [IDX_W-1:0]  field_index;
    } csvfs_result_t;

endpackage
`default_nettype wire

FILE: hdl/csvfs_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSV field splitter parse engine
// Holds the separator registers and the row parse state, and works out the
// result of one byte combinationally from the state registers.
// ----------------------------------------------------------------------------
module csvfs_parser #(
    parameter int SEP_MAX     = csvfs_pkg::SEP_MAX_DEFAULT,
    parameter int FIELD_LIMIT = csvfs_pkg::FIELD_LIMIT_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [csvfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [csvfs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                               in_accept,
    input  wire logic [csvfs_pkg::CHAR_W-1:0]       in_char,
    input  wire logic                               in_last,
    output csvfs_pkg::csvfs_result_t                result
);

    localparam int SEP_CAP = (SEP_MAX < 4) ? SEP_MAX : 4;
    localparam int CNT_W   = $clog2(FIELD_LIMIT);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FIELD_LIMIT - 1);

    logic [csvfs_pkg::SEPL_W-1:0] sep_length_reg;
    logic [csvfs_pkg::SEPC_W-1:0] sep_chars_reg;
    csvfs_pkg::parse_mode_t       mode_reg, mode_next, mode_work;
    logic [csvfs_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;

    logic [csvfs_pkg::SEPL_W-1:0] len_eff;
    logic [csvfs_pkg::SEPL_W-1:0] pos_inc;
    logic [csvfs_pkg::CHAR_W-1:0] first_byte;
    logic [csvfs_pkg::CHAR_W-1:0] next_byte;
    logic [csvfs_pkg::CHAR_W-1:0] ch;
    logic                         valid;
    logic                         fend;
    logic                         handled;

    // Separator byte k; an empty separator reads as a comma
    function automatic logic [csvfs_pkg::CHAR_W-1:0] sep_byte(
        input logic [csvfs_pkg::SEPL_W-1:0] len,
        input logic [csvfs_pkg::SEPC_W-1:0] chars,
        input logic [csvfs_pkg::POS_W-1:0]  k
    );
        logic [csvfs_pkg::CHAR_W-1:0] b;
        b = chars[k*csvfs_pkg::CHAR_W +: csvfs_pkg::CHAR_W];
        if (len == '0)
        begin
            b = csvfs_pkg::CH_COMMA;
        end
        return b;
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_length_reg <= csvfs_pkg::SEP_LENGTH_RESET;
            sep_chars_reg  <= csvfs_pkg::SEP_CHARS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                csvfs_pkg::CFG_SEP_LENGTH:
                    sep_length_reg <= cfg_data[csvfs_pkg::SEPL_W-1:0];
                csvfs_pkg::CFG_SEP_CHARS:
                    sep_chars_reg  <= cfg_data[csvfs_pkg::SEPC_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Effective separator length: empty counts as one, long ones are clamped
    always_comb
    begin
        if (sep_length_reg == '0)
        begin
            len_eff = csvfs_pkg::SEPL_W'(1);
        end
        else if (sep_length_reg > csvfs_pkg::SEPL_W'(SEP_CAP))
        begin
            len_eff = csvfs_pkg::SEPL_W'(SEP_CAP);
        end
        else
        begin
            len_eff = sep_length_reg;
        end
    end

    assign pos_inc    = csvfs_pkg::SEPL_W'(pos_reg) + csvfs_pkg::SEPL_W'(1);
    assign first_byte = sep_byte(sep_length_reg, sep_chars_reg, '0);
    assign next_byte  = sep_byte(sep_length_reg, sep_chars_reg,
                                 pos_inc[csvfs_pkg::POS_W-1:0]);

    // Parse state machine: next state and the result of this byte
    always_comb
    begin
        mode_work = mode_reg;
        pos_next  = pos_reg;
        handled   = 1'b0;
        ch        = '0;
        valid     = 1'b0;
        fend      = 1'b0;

        // Inside a multi-byte separator: swallow a matching byte or fall back
        if (mode_reg == csvfs_pkg::MODE_SEP)
        begin
            if ((pos_inc < len_eff) && (in_char == next_byte))
            begin
                pos_next = pos_inc[csvfs_pkg::POS_W-1:0];
                handled  = 1'b1;
            end
            else
            begin
                pos_next  = '0;
                mode_work = csvfs_pkg::MODE_UNQUOTED;
            end
        end

        mode_next = mode_work;
        if (!handled)
        begin
            unique case (mode_work)
                csvfs_pkg::MODE_UNQUOTED:
                begin
                    if (in_char == csvfs_pkg::CH_QUOTE)
                    begin
                        mode_next = csvfs_pkg::MODE_QUOTED;
                    end
                    else if (in_char == first_byte)
                    begin
                        fend      = 1'b1;
                        mode_next = csvfs_pkg::MODE_SEP;
                        pos_next  = '0;
                    end
                    else
                    begin
                        ch    = in_char;
                        valid = 1'b1;
                    end
                end
                csvfs_pkg::MODE_QUOTED:
                begin
                    if (in_char == csvfs_pkg::CH_QUOTE)
                    begin
                        mode_next = csvfs_pkg::MODE_QQUOTE;
                    end
                    else
                    begin
                        ch    = in_char;
                        valid = 1'b1;
                    end
                end
                csvfs_pkg::MODE_QQUOTE:
                begin
                    // A doubled quote is a literal; other bytes after a
                    // closing quote are dropped unless they start a separator.
                    if (in_char == csvfs_pkg::CH_QUOTE)
                    begin
                        ch        = csvfs_pkg::CH_QUOTE;
                        valid     = 1'b1;
                        mode_next = csvfs_pkg::MODE_QUOTED;
                    end
                    else if (in_char == first_byte)
                    begin
                        fend      = 1'b1;
                        mode_next = csvfs_pkg::MODE_SEP;
                        pos_next  = '0;
                    end
                    else
                    begin
                        mode_next = csvfs_pkg::MODE_UNQUOTED;
                    end
                end
                csvfs_pkg::MODE_SEP:
                begin
                    // Left the separator above, so this arm is never taken.
                    mode_next = mode_work;
                end
                default:
                begin
                    mode_next = csvfs_pkg::MODE_UNQUOTED;
                end
            endcase
        end

        // Field counter saturates at its top value
        cnt_next = cnt_reg;
        if (fend && (cnt_reg < CNT_MAX))
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        result.out_char    = ch;
        result.char_valid  = valid;
        result.field_end   = fend;
        result.row_end     = in_last;
        result.field_index = csvfs_pkg::IDX_W'(cnt_next);
    end

    // Parse state registers; the row state clears after its final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= csvfs_pkg::MODE_UNQUOTED;
            pos_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (in_accept)
        begin
            if (in_last)
            begin
                mode_reg <= csvfs_pkg::MODE_UNQUOTED;
                pos_reg  <= '0;
                cnt_reg  <= '0;
            end
            else
            begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/csv_field_splitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSV field splitter
// Splits a stream of row bytes into fields, handling quotes and separators.
// ----------------------------------------------------------------------------
// The block takes one byte request per clock cycle while s_tready is high and
// gives one result per byte, registered in the output buffer. The parse state
// is updated in the same cycle as the byte is accepted, so bytes may follow
// back to back; the results pass through a two-entry output buffer, so the input
// keeps taking bytes while one result waits on the output, and s_tready falls
// only when both entries are full. The separator registers should be written
// only while no row bytes are in flight.
module csv_field_splitter #(
    parameter int SEP_MAX     = csvfs_pkg::SEP_MAX_DEFAULT,
    parameter int FIELD_LIMIT = csvfs_pkg::FIELD_LIMIT_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [csvfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [csvfs_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // [7:0] in_char
    input  wire logic                             s_tlast,  // in_last
    // Output stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [23:0]                           m_tdata,  // [7:0] out_char,
                                                            // [17:8] field_index,
                                                            // [23:18] zero
    output logic [1:0]                            m_tuser,  // [0] char_valid,
                                                            // [1] field_end
    output logic                                  m_tlast   // row_end
);

    csvfs_pkg::csvfs_result_t result;
    csvfs_pkg::csvfs_result_t out_reg;
    csvfs_pkg::csvfs_result_t skid_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     skid_valid_reg, skid_valid_next;
    logic                     in_accept;
    logic                     pop;

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign pop       = out_valid_reg && m_tready;

    // Parse engine
    csvfs_parser #(
        .SEP_MAX     (SEP_MAX),
        .FIELD_LIMIT (FIELD_LIMIT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_char   (s_tdata[csvfs_pkg::CHAR_W-1:0]),
        .in_last   (s_tlast),
        .result    (result)
    );

    // Output buffer occupancy
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_accept;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg)
            begin
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (in_accept && (pop || !out_valid_reg))
        begin
            out_reg <= result;
        end

        if (in_accept && out_valid_reg && !pop)
        begin
            skid_reg <= result;
        end
    end

    // Output stream packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.field_index, out_reg.out_char};
    assign m_tuser  = {out_reg.field_end, out_reg.char_valid};
    assign m_tlast  = out_reg.row_end;

endmodule
`default_nettype wire
